// ===== src/dcpf_pkg.sv =====
package dcpf_pkg;

    localparam int BUFFER_BYTES = 62;
    localparam int ADDR_W       = $clog2(BUFFER_BYTES);
    localparam int CNT_W        = $clog2(BUFFER_BYTES + 1);
    localparam int BYTE_W       = 8;
    localparam int CFG_IDX_W    = 1;

    localparam logic [CFG_IDX_W-1:0] REG_POLL_CODE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_TICKS = 1'b1;

    localparam logic [BYTE_W-1:0] POLL_CODE_RST  = 8'hAA;
    localparam logic [BYTE_W-1:0] IDLE_TICKS_RST = 8'd3;
    localparam logic [BYTE_W-1:0] IDLE_MAX       = 8'd255;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [CNT_W-1:0]  t_count;

endpackage

// ===== src/dcpf_store.sv =====
module dcpf_store (
    input  logic           i_clk,
    input  logic           i_we,
    input  dcpf_pkg::t_addr i_waddr,
    input  dcpf_pkg::t_byte i_wdata,
    input  logic           i_re,
    input  dcpf_pkg::t_addr i_raddr,
    output dcpf_pkg::t_byte o_rdata
);
    import dcpf_pkg::*;

    t_byte r_mem [BUFFER_BYTES];
    t_byte r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/daisy_chain_poll_forwarder_core.sv =====
// A received byte or a tick that does not end a message gives no result. A tick that ends
// a poll message starts a flush: the stored bytes go out from the message memory (one read
// port, registered read) at one byte per cycle while the output is not stalled, then the
// node id and the sensor level: byte_count + 2 items. Input is stalled during a flush.
// Synchronous active-low reset clears control state and loads the register defaults; the
// message memory is not cleared.
module daisy_chain_poll_forwarder_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration write port
    input  logic                         i_cfg_we,
    input  logic [dcpf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [dcpf_pkg::BYTE_W-1:0]  i_cfg_data,
    // input item channel
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_op,
    input  logic [dcpf_pkg::BYTE_W-1:0]  i_rx_byte,
    input  logic                         i_sensor_level,
    // result item channel
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [dcpf_pkg::BYTE_W-1:0]  o_out_byte,
    output logic                         o_last
);
    import dcpf_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_BYTES = 2'd1;
    localparam logic [1:0] ST_ID    = 2'd2;
    localparam logic [1:0] ST_LEVEL = 2'd3;

    logic [1:0] r_state, n_state;

    // configuration registers
    t_byte r_poll_code, r_idle_ticks;

    // message state
    t_count r_count, n_count;
    logic   r_waiting, n_waiting;
    t_byte  r_idle, n_idle;
    logic   r_held, n_held;
    t_byte  r_first, n_first;

    // flush state
    t_count r_idx, n_idx;
    logic   r_pend, n_pend;

    // output register
    logic   r_o_valid, n_o_valid;
    t_byte  r_o_byte, n_o_byte;
    logic   r_o_last, n_o_last;

    // memory access
    logic   mem_we, mem_re;
    t_byte  mem_rdata;

    logic   in_acc, out_free, load_pend;
    t_byte  idle_inc, node_id;
    logic [CNT_W:0] id_sum;

    dcpf_store u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata (i_rx_byte),
        .i_re    (mem_re),
        .i_raddr (r_idx[ADDR_W-1:0]),
        .o_rdata (mem_rdata)
    );

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    // output slot is free when empty or being taken this cycle
    assign out_free   = !r_o_valid || !i_out_stall;
    assign load_pend  = (r_state == ST_BYTES) && r_pend && out_free;

    assign idle_inc = (r_idle < IDLE_MAX) ? r_idle + 8'd1 : r_idle;
    // node id is (count - 1) / 2 + 1, i.e. (count + 1) / 2 for a non-empty message
    assign id_sum   = {1'b0, r_count} + {{CNT_W{1'b0}}, 1'b1};
    assign node_id  = BYTE_W'(id_sum >> 1);

    // store a byte while there is room
    assign mem_we = in_acc && (i_op == OP_BYTE) && (r_count < t_count'(BUFFER_BYTES));
    // read ahead while bytes remain and the read register is free or draining
    assign mem_re = (r_state == ST_BYTES) && (r_idx < r_count) && (!r_pend || load_pend);

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_waiting = r_waiting;
        n_idle    = r_idle;
        n_held    = r_held;
        n_first   = r_first;
        n_idx     = r_idx;
        n_pend    = r_pend;
        n_o_valid = r_o_valid && i_out_stall;
        n_o_byte  = r_o_byte;
        n_o_last  = r_o_last;

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_op == OP_BYTE) begin
                        // latch sensor level with the first byte of a message
                        if (!r_waiting) begin
                            n_held = i_sensor_level;
                        end
                        if (r_count == '0) begin
                            n_first = i_rx_byte;
                        end
                        if (mem_we) begin
                            n_count = r_count + 1'b1;
                        end
                        n_waiting = 1'b1;
                        n_idle    = '0;
                    end else if (r_waiting) begin
                        n_idle = idle_inc;
                        if (idle_inc >= r_idle_ticks) begin
                            // message done: flush a poll, drop anything else
                            n_waiting = 1'b0;
                            n_idle    = '0;
                            if (r_count != '0 && r_first == r_poll_code) begin
                                n_state = ST_BYTES;
                                n_idx   = '0;
                                n_pend  = 1'b0;
                            end else begin
                                n_count = '0;
                            end
                        end
                    end
                end
            end
            ST_BYTES: begin
                if (load_pend) begin
                    n_o_valid = 1'b1;
                    n_o_byte  = mem_rdata;
                    n_o_last  = 1'b0;
                end
                if (mem_re) begin
                    n_idx  = r_idx + 1'b1;
                    n_pend = 1'b1;
                end else if (load_pend) begin
                    n_pend = 1'b0;
                end
                if (r_idx == r_count && !r_pend) begin
                    n_state = ST_ID;
                end
            end
            ST_ID: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_o_byte  = node_id;
                    n_o_last  = 1'b0;
                    n_state   = ST_LEVEL;
                end
            end
            ST_LEVEL: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_o_byte  = {{(BYTE_W-1){1'b0}}, r_held};
                    n_o_last  = 1'b1;
                    n_count   = '0;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_count      <= '0;
            r_waiting    <= 1'b0;
            r_idle       <= '0;
            r_held       <= 1'b0;
            r_idx        <= '0;
            r_pend       <= 1'b0;
            r_o_valid    <= 1'b0;
            r_poll_code  <= POLL_CODE_RST;
            r_idle_ticks <= IDLE_TICKS_RST;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_waiting <= n_waiting;
            r_idle    <= n_idle;
            r_held    <= n_held;
            r_idx     <= n_idx;
            r_pend    <= n_pend;
            r_o_valid <= n_o_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_POLL_CODE:  r_poll_code  <= i_cfg_data;
                    REG_IDLE_TICKS: r_idle_ticks <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_first  <= n_first;
        r_o_byte <= n_o_byte;
        r_o_last <= n_o_last;
    end

    assign o_out_valid = r_o_valid;
    assign o_out_byte  = r_o_byte;
    assign o_last      = r_o_last;

endmodule

// ===== src/dcpf_checker.sv =====
module dcpf_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_cfg_we,
    input logic [dcpf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input logic [dcpf_pkg::BYTE_W-1:0]    i_cfg_data,
    input logic                           i_in_valid,
    input logic                           o_in_stall,
    input logic                           i_op,
    input logic [dcpf_pkg::BYTE_W-1:0]    i_rx_byte,
    input logic                           i_sensor_level,
    input logic                           o_out_valid,
    input logic                           i_out_stall,
    input logic [dcpf_pkg::BYTE_W-1:0]    o_out_byte,
    input logic                           o_last
);

    // no result straight out of reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_out_byte) && $stable(o_last))
        else $error("stalled result changed");

    // the final item of a reply carries only the sensor bit
    a_last_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last |-> o_out_byte[7:1] == 7'd0)
        else $error("final item is not a sensor level");

    // forwarded bytes and the node id only appear during a flush
    a_flush_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last |-> o_in_stall)
        else $error("input open while a reply is in progress");

endmodule

bind daisy_chain_poll_forwarder_core dcpf_checker u_dcpf_checker (.*);
